// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL of the page table block.
// Each macro wraps one concurrent assertion clocked on clk with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_ALWAYS(label, clk, rst_n, (ante) |-> (cons), msg)

// Antecedent this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_ALWAYS(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- sv/slpt_pkg.sv -----
// Types and constants of the second-level page table: command and status codes,
// descriptor and access bit positions, and the structs returned by the codec.
package slpt_pkg;

    typedef enum logic [1:0] {
        CMD_MAP    = 2'd0,
        CMD_UNMAP  = 2'd1,
        CMD_LOOKUP = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_EXISTS  = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    localparam int DESC_W = 32;
    localparam int REQ_W  = 5;
    localparam int ACC_W  = 7;

    // Descriptor bits
    localparam int D_XN      = 0;
    localparam int D_PRESENT = 1;
    localparam int D_B       = 2;
    localparam int D_C       = 3;
    localparam int D_AP_SYS  = 4;
    localparam int D_AP_USER = 5;
    localparam int D_TEX0    = 6;
    localparam int D_APX     = 9;

    // Requested access bits
    localparam int REQ_EXEC     = 0;
    localparam int REQ_USER     = 1;
    localparam int REQ_WRITE    = 2;
    localparam int REQ_DEVICE   = 3;
    localparam int REQ_UNCACHED = 4;

    // Returned access bits
    localparam int ACC_READ     = 0;
    localparam int ACC_USER     = 1;
    localparam int ACC_WRITE    = 2;
    localparam int ACC_DEVICE   = 3;
    localparam int ACC_UNCACHED = 4;
    localparam int ACC_INNER    = 5;
    localparam int ACC_OUTER    = 6;

    // TEX[0],C,B patterns
    localparam logic [2:0] TYPE_DEVICE   = 3'b001;
    localparam logic [2:0] TYPE_UNCACHED = 3'b100;
    localparam logic [2:0] TYPE_WB       = 3'b111;

    typedef struct packed {
        status_t            status;
        logic [DESC_W-1:0]  phys;
        logic [ACC_W-1:0]   access;
    } slpt_result_t;

    typedef struct packed {
        logic               mem_we;
        logic               valid_we;
        logic               valid_val;
        logic [DESC_W-1:0]  data;
    } slpt_write_t;

endpackage

// ----- sv/slpt_req_if.sv -----
// Request channel of the page table: command, addresses and requested access.
// Depends on slpt_pkg for field widths.
interface slpt_req_if
    import slpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [31:0]        virt_addr;
    logic [31:0]        phys_addr;
    logic [REQ_W-1:0]   access_request;

    modport source (output valid, command, virt_addr, phys_addr, access_request,
                    input ready);
    modport sink   (input valid, command, virt_addr, phys_addr, access_request,
                    output ready);
endinterface

// ----- sv/slpt_rsp_if.sv -----
// Result channel of the page table: status, frame address and decoded access.
// Depends on slpt_pkg for field widths.
interface slpt_rsp_if
    import slpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        phys_out;
    logic [ACC_W-1:0]   access_out;

    modport source (output valid, status, phys_out, access_out, input ready);
    modport sink   (input valid, status, phys_out, access_out, output ready);
endinterface

// ----- sv/slpt_codec.sv -----
// Descriptor codec: from the command, the stored entry and the request it forms
// the result and the table write. Depends on slpt_pkg.
module slpt_codec
    import slpt_pkg::*;
#(
    parameter int PAGE_SHIFT_BITS = 12
) (
    input  logic [1:0]                       command,
    input  logic                             present,
    input  logic [DESC_W-1:0]                entry,
    input  logic [DESC_W-PAGE_SHIFT_BITS-1:0] frame,
    input  logic [REQ_W-1:0]                 access_request,
    output slpt_result_t                     result,
    output slpt_write_t                      wr
);
    logic [PAGE_SHIFT_BITS-1:0] flags;
    logic [2:0]                 mem_type;
    logic [ACC_W-1:0]           acc;

    // Encode flags of a new descriptor; device wins over uncached
    always_comb
    begin
        flags             = '0;
        flags[D_PRESENT]  = 1'b1;
        flags[D_AP_SYS]   = 1'b1;
        flags[D_XN]       = ~access_request[REQ_EXEC];
        flags[D_AP_USER]  = access_request[REQ_USER];
        flags[D_APX]      = ~access_request[REQ_WRITE];
        if (access_request[REQ_DEVICE])
        begin
            {flags[D_TEX0], flags[D_C], flags[D_B]} = TYPE_DEVICE;
        end
        else if (access_request[REQ_UNCACHED])
        begin
            {flags[D_TEX0], flags[D_C], flags[D_B]} = TYPE_UNCACHED;
        end
        else
        begin
            {flags[D_TEX0], flags[D_C], flags[D_B]} = TYPE_WB;
        end
    end

    // Decode the stored entry; any pattern but device or uncached reads as cached
    assign mem_type = {entry[D_TEX0], entry[D_C], entry[D_B]};

    always_comb
    begin
        acc            = '0;
        acc[ACC_READ]  = 1'b1;
        acc[ACC_USER]  = entry[D_AP_USER];
        acc[ACC_WRITE] = ~entry[D_APX];
        if (mem_type == TYPE_DEVICE)
        begin
            acc[ACC_DEVICE] = 1'b1;
        end
        else if (mem_type == TYPE_UNCACHED)
        begin
            acc[ACC_UNCACHED] = 1'b1;
        end
        else
        begin
            acc[ACC_INNER] = 1'b1;
            acc[ACC_OUTER] = 1'b1;
        end
    end

    always_comb
    begin
        result.status = ST_INVALID;
        result.phys   = '0;
        result.access = '0;
        wr.mem_we     = 1'b0;
        wr.valid_we   = 1'b0;
        wr.valid_val  = 1'b0;
        wr.data       = {frame, flags};
        case (command)
            CMD_MAP:
            begin
                if (present)
                begin
                    result.status = ST_EXISTS;
                end
                else
                begin
                    result.status = ST_SUCCESS;
                    wr.mem_we     = 1'b1;
                    wr.valid_we   = 1'b1;
                    wr.valid_val  = 1'b1;
                end
            end
            CMD_UNMAP:
            begin
                result.status = ST_SUCCESS;
                wr.valid_we   = 1'b1;
            end
            CMD_LOOKUP:
            begin
                if (present)
                begin
                    result.status = ST_SUCCESS;
                    result.phys   = {entry[DESC_W-1:PAGE_SHIFT_BITS],
                                     {PAGE_SHIFT_BITS{1'b0}}};
                    result.access = acc;
                end
            end
            default:
            begin
                result.status = ST_INVALID;
            end
        endcase
    end

endmodule

// ----- sv/second_level_page_table.sv -----
// A request accepted is held in stage 1 while its entry is read; its result is then
// registered and offered on rsp. Throughput: one request per cycle unless rsp stalls;
// the table memory has one read and one write port, and a write in flight is forwarded
// to a request reading the same entry. Reset: present bits of all TABLE_ENTRIES entries
// clear at once, so the table is usable right after reset; entry data need no clearing.
`include "assert_macros.svh"

module second_level_page_table
    import slpt_pkg::*;
#(
    parameter int TABLE_ENTRIES   = 256,   // power of two
    parameter int PAGE_SHIFT_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    slpt_req_if.sink    req,
    slpt_rsp_if.source  rsp
);
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int FRAME_W = DESC_W - PAGE_SHIFT_BITS;

    logic [DESC_W-1:0]        table_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // Stage 1: request held while the entry is read
    logic                     s1_valid_reg;
    logic [1:0]               s1_cmd_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [FRAME_W-1:0]       s1_frame_reg;
    logic [REQ_W-1:0]         s1_req_reg;
    logic [DESC_W-1:0]        rdata_reg;
    logic                     pres_reg;
    logic                     byp_hit_reg;
    logic [DESC_W-1:0]        byp_data_reg;

    // Result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    logic [DESC_W-1:0]        phys_reg;
    logic [ACC_W-1:0]         access_reg;

    logic                     adv;
    logic                     accept;
    logic [IDX_W-1:0]         in_idx;
    logic                     byp_hit;
    logic [DESC_W-1:0]        entry;
    slpt_result_t             result;
    slpt_write_t              wr;

    assign adv        = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || adv;
    assign accept     = req.valid && req.ready;
    assign in_idx     = req.virt_addr[PAGE_SHIFT_BITS +: IDX_W];
    // Write committing at this edge to the entry being read
    assign byp_hit    = adv && wr.valid_we && (s1_idx_reg == in_idx);
    assign entry      = byp_hit_reg ? byp_data_reg : rdata_reg;

    slpt_codec #(
        .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
    ) u_codec (
        .command        (s1_cmd_reg),
        .present        (pres_reg),
        .entry          (entry),
        .frame          (s1_frame_reg),
        .access_request (s1_req_reg),
        .result         (result),
        .wr             (wr)
    );

    always_ff @(posedge clk)
    begin
        if (adv && wr.mem_we)
        begin
            table_mem[s1_idx_reg] <= wr.data;
        end
        if (accept)
        begin
            rdata_reg <= table_mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= req.command;
            s1_idx_reg   <= in_idx;
            s1_frame_reg <= req.phys_addr[DESC_W-1:PAGE_SHIFT_BITS];
            s1_req_reg   <= req.access_request;
            pres_reg     <= byp_hit ? wr.valid_val : valid_reg[in_idx];
            byp_hit_reg  <= byp_hit;
            byp_data_reg <= wr.data;
        end
        if (adv)
        begin
            status_reg <= result.status;
            phys_reg   <= result.phys;
            access_reg <= result.access;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv && wr.valid_we)
            begin
                valid_reg[s1_idx_reg] <= wr.valid_val;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.phys_out   = phys_reg;
    assign rsp.access_out = access_reg;

    `ASSERT_IMPLIES(a_stall_blocks_req, clk, rst_n,
        s1_valid_reg && out_valid_reg && !rsp.ready, !req.ready,
        "request taken while both stages are stalled")
    `ASSERT_NEXT(a_valid_written, clk, rst_n, adv && wr.valid_we,
        valid_reg[$past(s1_idx_reg)] == $past(wr.valid_val),
        "present bit not updated")
    `ASSERT_IMPLIES(a_access_only_on_success, clk, rst_n,
        out_valid_reg && (access_reg != '0),
        (status_reg == ST_SUCCESS) && access_reg[ACC_READ],
        "access bits without a successful lookup")
    `ASSERT_IMPLIES(a_phys_only_on_lookup, clk, rst_n,
        out_valid_reg && (phys_reg != '0), access_reg[ACC_READ],
        "frame returned outside a lookup")

endmodule

// ----- sim/tb_second_level_page_table.sv -----
// Self-checking testbench for second_level_page_table: directed and random map, unmap
// and lookup requests checked against a behavioural copy of the descriptor table.
// Depends on slpt_pkg, slpt_req_if, slpt_rsp_if and the page table RTL.
module tb_second_level_page_table;
    import slpt_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int TABLE_SIZE      = 256;
    localparam int PAGE_SHIFT      = 12;
    localparam int INDEX_W         = 8;
    localparam int PHASE_REQUESTS  = 360;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 8;

    // Command code the block treats as a no-op
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [31:0]      virt_addr;
        logic [31:0]      phys_addr;
        logic [REQ_W-1:0] access_request;
    } page_request_t;

    logic clk;
    logic rst_n;

    slpt_req_if req_if ();
    slpt_rsp_if rsp_if ();

    second_level_page_table #(
        .TABLE_ENTRIES   (TABLE_SIZE),
        .PAGE_SHIFT_BITS (PAGE_SHIFT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [31:0]   page_table [TABLE_SIZE];
    page_request_t pending_q [$];
    slpt_result_t  expected_results_q [$];

    int   error_count   = 0;
    int   tx_idle_pct   = 0;
    int   rx_stall_pct  = 0;
    int   hold_off_gen  = 0;
    int   hold_off_seen = 0;
    int   hold_off_left = 0;
    logic req_taken     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    // Descriptor table update and expected result for one request
    function automatic slpt_result_t apply_table_op(page_request_t r);
        logic [INDEX_W-1:0] idx;
        logic [31:0]        entry;
        logic [31:0]        desc;
        logic [31:0]        frame_mask;
        logic [2:0]         mem_type;
        slpt_result_t       res;
        idx        = r.virt_addr[PAGE_SHIFT +: INDEX_W];
        entry      = page_table[idx];
        frame_mask = ~((32'd1 << PAGE_SHIFT) - 32'd1);
        res.status = ST_INVALID;
        res.phys   = '0;
        res.access = '0;
        case (r.command)
            CMD_MAP:
            begin
                if (entry[D_PRESENT])
                begin
                    res.status = ST_EXISTS;
                end
                else
                begin
                    desc             = r.phys_addr & frame_mask;
                    desc[D_PRESENT]  = 1'b1;
                    desc[D_AP_SYS]   = 1'b1;
                    desc[D_XN]       = ~r.access_request[REQ_EXEC];
                    desc[D_AP_USER]  = r.access_request[REQ_USER];
                    desc[D_APX]      = ~r.access_request[REQ_WRITE];
                    // device takes priority over uncached
                    if (r.access_request[REQ_DEVICE])
                        mem_type = TYPE_DEVICE;
                    else if (r.access_request[REQ_UNCACHED])
                        mem_type = TYPE_UNCACHED;
                    else
                        mem_type = TYPE_WB;
                    {desc[D_TEX0], desc[D_C], desc[D_B]} = mem_type;
                    page_table[idx] = desc;
                    res.status      = ST_SUCCESS;
                end
            end
            CMD_UNMAP:
            begin
                page_table[idx] = '0;
                res.status      = ST_SUCCESS;
            end
            CMD_LOOKUP:
            begin
                if (entry[D_PRESENT])
                begin
                    res.status           = ST_SUCCESS;
                    res.phys             = entry & frame_mask;
                    res.access[ACC_READ] = 1'b1;
                    res.access[ACC_USER] = entry[D_AP_USER];
                    res.access[ACC_WRITE] = ~entry[D_APX];
                    mem_type = {entry[D_TEX0], entry[D_C], entry[D_B]};
                    if (mem_type == TYPE_DEVICE)
                        res.access[ACC_DEVICE] = 1'b1;
                    else if (mem_type == TYPE_UNCACHED)
                        res.access[ACC_UNCACHED] = 1'b1;
                    else
                    begin
                        res.access[ACC_INNER] = 1'b1;
                        res.access[ACC_OUTER] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic add_request(logic [1:0] cmd, logic [31:0] va, logic [31:0] pa,
                               logic [REQ_W-1:0] acc);
        page_request_t r;
        r.command        = cmd;
        r.virt_addr      = va;
        r.phys_addr      = pa;
        r.access_request = acc;
        pending_q.push_back(r);
    endtask

    task automatic queue_random_requests(int count);
        page_request_t r;
        int            pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                r.command = CMD_MAP;
            else if (pick < 55)
                r.command = CMD_UNMAP;
            else if (pick < 95)
                r.command = CMD_LOOKUP;
            else
                r.command = CMD_RESERVED;
            r.virt_addr = $urandom();
            // mostly a small hot set of entries so lookups and remaps hit mapped pages
            if ($urandom_range(99) < 70)
                r.virt_addr[PAGE_SHIFT +: INDEX_W] = INDEX_W'($urandom_range(15) * 17);
            r.phys_addr      = $urandom();
            r.access_request = REQ_W'($urandom_range(31));
            pending_q.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_if.valid || expected_results_q.size() != 0)
            @(posedge clk);
    endtask

    // Request driver
    always @(negedge clk)
    begin : drive_requests
        page_request_t item;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (req_if.valid && !req_taken)
        begin
            // hold the request until it is taken
        end
        else if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
        begin
            item                  = pending_q.pop_front();
            req_if.valid          <= 1'b1;
            req_if.command        <= item.command;
            req_if.virt_addr      <= item.virt_addr;
            req_if.phys_addr      <= item.phys_addr;
            req_if.access_request <= item.access_request;
        end
        else
        begin
            req_if.valid <= 1'b0;
        end
    end

    // Result back-pressure, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_seen != hold_off_gen)
        begin
            hold_off_seen = hold_off_gen;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: check results, then record the request taken at this edge
    always @(posedge clk)
    begin : monitor
        slpt_result_t  expected;
        page_request_t taken;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_results_q.size() == 0)
                begin
                    $error("unexpected result: status %0d phys_out %h access_out %h",
                           rsp_if.status, rsp_if.phys_out, rsp_if.access_out);
                    error_count++;
                end
                else
                begin
                    expected = expected_results_q.pop_front();
                    if (rsp_if.status !== expected.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               expected.status, rsp_if.status);
                        error_count++;
                    end
                    if (rsp_if.phys_out !== expected.phys)
                    begin
                        $error("phys_out: expected %h, actual %h",
                               expected.phys, rsp_if.phys_out);
                        error_count++;
                    end
                    if (rsp_if.access_out !== expected.access)
                    begin
                        $error("access_out: expected %h, actual %h",
                               expected.access, rsp_if.access_out);
                        error_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                taken.command        = req_if.command;
                taken.virt_addr      = req_if.virt_addr;
                taken.phys_addr      = req_if.phys_addr;
                taken.access_request = req_if.access_request;
                expected_results_q.push_back(apply_table_op(taken));
                req_taken = 1'b1;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
            page_table[i] = '0;
        req_if.valid          = 1'b0;
        req_if.command        = CMD_MAP;
        req_if.virt_addr      = '0;
        req_if.phys_addr      = '0;
        req_if.access_request = '0;
        rsp_if.ready          = 1'b0;
        rst_n                 = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, every cache type, reserved command, aliasing
        add_request(CMD_LOOKUP,   32'h0000_0000, 32'h0000_0000, 5'h00);
        add_request(CMD_UNMAP,    32'hFFFF_FFFF, 32'h0000_0000, 5'h00);
        add_request(CMD_RESERVED, 32'h0000_0000, 32'hFFFF_FFFF, 5'h1F);
        add_request(CMD_MAP,      32'h0000_0000, 32'hFFFF_FFFF, 5'h00);
        add_request(CMD_LOOKUP,   32'h0000_0FFF, 32'h0000_0000, 5'h00);
        add_request(CMD_MAP,      32'h0000_0000, 32'h1234_5000, 5'h1F);
        add_request(CMD_MAP,      32'hFFFF_FFFF, 32'h0000_0000, 5'h1F);
        add_request(CMD_LOOKUP,   32'h000F_F000, 32'hFFFF_FFFF, 5'h00);
        add_request(CMD_MAP,      32'h0000_1000, 32'h1234_5ABC, 5'h16);
        add_request(CMD_LOOKUP,   32'h8000_1234, 32'h0000_0000, 5'h00);
        add_request(CMD_MAP,      32'h0000_2000, 32'hA5A5_A5A5, 5'h08);
        add_request(CMD_LOOKUP,   32'h0000_2000, 32'h0000_0000, 5'h00);
        add_request(CMD_MAP,      32'h0000_3000, 32'h5A5A_5A5A, 5'h07);
        add_request(CMD_LOOKUP,   32'h0000_3000, 32'h0000_0000, 5'h00);
        add_request(CMD_MAP,      32'h0000_4000, 32'h0F0F_F000, 5'h10);
        add_request(CMD_LOOKUP,   32'h0000_4000, 32'h0000_0000, 5'h00);
        // reserved command on a mapped page leaves it intact
        add_request(CMD_RESERVED, 32'h0000_4000, 32'h0000_0000, 5'h00);
        add_request(CMD_LOOKUP,   32'h0000_4000, 32'h0000_0000, 5'h00);
        // index aliasing through the upper address bits
        add_request(CMD_MAP,      32'hABC0_1000, 32'h0000_0000, 5'h00);
        add_request(CMD_UNMAP,    32'h7770_1FFF, 32'h0000_0000, 5'h00);
        add_request(CMD_LOOKUP,   32'h0000_1000, 32'h0000_0000, 5'h00);
        add_request(CMD_MAP,      32'h0000_1000, 32'hFEDC_B000, 5'h03);
        add_request(CMD_LOOKUP,   32'h0000_1000, 32'h0000_0000, 5'h00);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        queue_random_requests(PHASE_REQUESTS);
        wait_drained();

        tx_idle_pct  = 66;
        rx_stall_pct = 0;
        queue_random_requests(PHASE_REQUESTS);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 66;
        queue_random_requests(PHASE_REQUESTS);
        wait_drained();

        tx_idle_pct  = 6;
        rx_stall_pct = 6;
        queue_random_requests(PHASE_REQUESTS);
        wait_drained();

        // receiver holds off while requests keep coming, so the pipeline backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        queue_random_requests(PHASE_REQUESTS);
        @(posedge clk);
        hold_off_gen = hold_off_gen + 1;
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
